// ----- design/col_pkg.sv -----
// col_pkg: shared types, codes and lookup tables of the coreset0 occasion locator
// no dependencies; used by the interfaces, all modules and the checker
package col_pkg;

  // field widths
  localparam int FRAME_W   = 10;
  localparam int SLOT_W    = 5;
  localparam int RBS_W     = 7;
  localparam int SYM_W     = 2;
  localparam int OFF_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 4;

  // slots per frame for each numerology
  localparam logic [5:0] NSLOT_15 = 6'd10;
  localparam logic [5:0] NSLOT_30 = 6'd20;

  // reserved row of the 15 kHz coreset table
  localparam logic [3:0] CSET_RESERVED = 4'd15;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MIB   = 2'd1,
    STAT_RESERVED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCS     = 3'd0,
    REG_CORESET = 3'd1,
    REG_SEARCH  = 3'd2,
    REG_BEAM    = 3'd3,
    REG_VALID   = 3'd4
  } cfg_reg_e;

  // coreset0 tables, 15 kHz
  localparam logic [RBS_W-1:0] RBS_15 [16] = '{
    7'd24, 7'd24, 7'd24, 7'd24, 7'd24, 7'd24, 7'd48, 7'd48,
    7'd48, 7'd48, 7'd48, 7'd48, 7'd96, 7'd96, 7'd96, 7'd0};
  localparam logic [SYM_W-1:0] SYM_15 [16] = '{
    2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [OFF_W-1:0] OFF_15 [16] = '{
    6'd0, 6'd2, 6'd4, 6'd0, 6'd2, 6'd4, 6'd12, 6'd16,
    6'd12, 6'd16, 6'd12, 6'd16, 6'd38, 6'd38, 6'd38, 6'd0};

  // coreset0 tables, 30 kHz
  localparam logic [RBS_W-1:0] RBS_30 [16] = '{
    7'd24, 7'd24, 7'd24, 7'd24, 7'd24, 7'd24, 7'd24, 7'd24,
    7'd24, 7'd24, 7'd48, 7'd48, 7'd48, 7'd48, 7'd48, 7'd48};
  localparam logic [SYM_W-1:0] SYM_30 [16] = '{
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3,
    2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [OFF_W-1:0] OFF_30 [16] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd1, 6'd2,
    6'd3, 6'd4, 6'd12, 6'd14, 6'd16, 6'd12, 6'd14, 6'd16};

  // search space zero table: slot offset O, M in half units, first symbol
  localparam logic [2:0] SS_O [16] = '{
    3'd0, 3'd0, 3'd2, 3'd2, 3'd5, 3'd5, 3'd7, 3'd7,
    3'd0, 3'd5, 3'd0, 3'd0, 3'd2, 3'd2, 3'd5, 3'd5};
  localparam logic [2:0] SS_MHALF [16] = '{
    3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1,
    3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
  localparam logic [SYM_W-1:0] SS_FSYM [16] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2};

  // everything that follows from the configuration alone
  typedef struct packed {
    status_e          status;
    logic             scs;
    logic [RBS_W-1:0] rbs;
    logic [SYM_W-1:0] sym;
    logic [OFF_W-1:0] rb_off;
    logic [4:0]       n0;
    logic             odd;
    logic [SYM_W-1:0] fsym;
    logic [5:0]       offset;   // n0 + N * parity, position in the two-frame period
  } info_t;

  // one result word
  typedef struct packed {
    status_e          status;
    logic             is_occasion;
    logic [RBS_W-1:0] rbs;
    logic [SYM_W-1:0] sym;
    logic [OFF_W-1:0] rb_off;
    logic [4:0]       start_slot;
    logic             odd;
    logic [SYM_W-1:0] fsym;
  } result_t;

endpackage

// ----- design/col_query_if.sv -----
// col_query_if: valid/ready channel that carries one frame and slot query word
// depends on col_pkg for field widths
interface col_query_if import col_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_number;
  logic [SLOT_W-1:0]  slot_number;

  modport source (output valid, frame_number, slot_number, input ready);
  modport sink   (input valid, frame_number, slot_number, output ready);
endinterface

// ----- design/col_result_if.sv -----
// col_result_if: valid/ready channel that carries one occasion result word
// depends on col_pkg for field widths
interface col_result_if import col_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               is_occasion;
  logic [RBS_W-1:0]   coreset_rbs;
  logic [SYM_W-1:0]   coreset_symbols;
  logic [OFF_W-1:0]   coreset_rb_offset;
  logic [SLOT_W-1:0]  start_slot;
  logic               odd_frame;
  logic [SYM_W-1:0]   first_symbol;

  modport source (output valid, status, is_occasion, coreset_rbs, coreset_symbols,
                  coreset_rb_offset, start_slot, odd_frame, first_symbol, input ready);
  modport sink   (input valid, status, is_occasion, coreset_rbs, coreset_symbols,
                  coreset_rb_offset, start_slot, odd_frame, first_symbol, output ready);
endinterface

// ----- design/col_lookup.sv -----
// col_lookup: configuration registers and the registered table lookup behind them
// depends on col_pkg (tables, codes, info_t)
module col_lookup import col_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 scs_o,
  output info_t                info_o
);

  logic       scs_q;
  logic [3:0] cset_q;
  logic [3:0] ss_q;
  logic [2:0] beam_q;
  logic       valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scs_q   <= 1'b0;
      cset_q  <= 4'd0;
      ss_q    <= 4'd0;
      beam_q  <= 3'd0;
      valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SCS:     scs_q   <= cfg_data_i[0];
        REG_CORESET: cset_q  <= cfg_data_i;
        REG_SEARCH:  ss_q    <= cfg_data_i;
        REG_BEAM:    beam_q  <= cfg_data_i[2:0];
        REG_VALID:   valid_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [2:0] o_val;
  logic [2:0] mhalf;
  logic [3:0] o_sh;
  logic [5:0] prod;
  logic [4:0] total;
  logic [5:0] offs;
  logic [5:0] nsl;
  logic [5:0] n0_full;
  logic       odd;
  info_t      info_d;
  info_t      info_q;

  // slot offset, start slot and frame parity
  always_comb begin
    o_val = SS_O[ss_q];
    mhalf = SS_MHALF[ss_q];
    prod  = {3'b000, beam_q} * {3'b000, mhalf};
    o_sh  = scs_q ? {o_val, 1'b0} : {1'b0, o_val};
    total = {1'b0, o_sh} + prod[5:1];
    nsl   = scs_q ? NSLOT_30 : NSLOT_15;
    // total stays below 40, so only the 15 kHz period of 20 needs a wrap
    if (!scs_q && (total >= 5'd20)) begin
      offs = {1'b0, total} - 6'd20;
    end else begin
      offs = {1'b0, total};
    end
    odd     = (offs >= nsl);
    n0_full = odd ? (offs - nsl) : offs;
  end

  // table lookup and error checks
  always_comb begin
    info_d        = '0;
    info_d.scs    = scs_q;
    info_d.n0     = n0_full[4:0];
    info_d.odd    = odd;
    info_d.offset = offs;
    if (scs_q) begin
      info_d.rbs    = RBS_30[cset_q];
      info_d.sym    = SYM_30[cset_q];
      info_d.rb_off = OFF_30[cset_q];
    end else begin
      info_d.rbs    = RBS_15[cset_q];
      info_d.sym    = SYM_15[cset_q];
      info_d.rb_off = OFF_15[cset_q];
    end
    // alternating rows: odd beams start right after the coreset
    if ((ss_q inside {4'd1, 4'd3, 4'd5, 4'd7}) && beam_q[0]) begin
      info_d.fsym = info_d.sym;
    end else begin
      info_d.fsym = SS_FSYM[ss_q];
    end
    info_d.status = STAT_OK;
    if (!valid_q) begin
      info_d        = '0;
      info_d.status = STAT_NO_MIB;
    end else if (!scs_q && (cset_q == CSET_RESERVED)) begin
      info_d        = '0;
      info_d.status = STAT_RESERVED;
    end
  end

  // lookup register, read by the last pipeline stage only
  always_ff @(posedge clk_i) begin
    info_q <= info_d;
  end

  assign scs_o  = scs_q;
  assign info_o = info_q;

endmodule

// ----- design/col_pipe.sv -----
// col_pipe: four-stage pipeline that places a frame/slot in the two-frame period
// and compares it with the monitoring window; depends on col_pkg
module col_pipe import col_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              scs_i,
  input  info_t             info_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              frame_lsb_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           result_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // a stage loads when it is empty or its word moves on
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  logic              lsb1_q;
  logic [SLOT_W-1:0] slot1_q;
  logic [5:0]        sum_d, sum2_q;
  logic [5:0]        abs_d, abs3_q;
  logic [6:0]        period;
  logic [6:0]        diff;
  logic [6:0]        gap;
  result_t           res_d, res_q;

  // stage 2: frame parity times N plus slot
  always_comb begin
    sum_d = (lsb1_q ? (scs_i ? NSLOT_30 : NSLOT_15) : 6'd0) + {1'b0, slot1_q};
  end

  // stage 3: reduce to the two-frame period (sum stays below 52)
  always_comb begin
    if (sum2_q >= 6'd40) begin
      abs_d = sum2_q - 6'd40;
    end else if (!scs_i && (sum2_q >= 6'd20)) begin
      abs_d = sum2_q - 6'd20;
    end else begin
      abs_d = sum2_q;
    end
  end

  // stage 4: distance from window start, result word
  always_comb begin
    period = info_i.scs ? {NSLOT_30, 1'b0} : {NSLOT_15, 1'b0};
    diff   = {1'b0, abs3_q} + period - {1'b0, info_i.offset};
    gap    = (diff >= period) ? (diff - period) : diff;
    res_d.status      = info_i.status;
    res_d.is_occasion = (info_i.status == STAT_OK) && (gap < 7'd2);
    res_d.rbs         = info_i.rbs;
    res_d.sym         = info_i.sym;
    res_d.rb_off      = info_i.rb_off;
    res_d.start_slot  = info_i.n0;
    res_d.odd         = info_i.odd;
    res_d.fsym        = info_i.fsym;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      lsb1_q  <= frame_lsb_i;
      slot1_q <= slot_i;
    end
    if (en2) sum2_q <= sum_d;
    if (en3) abs3_q <= abs_d;
    if (en4) res_q  <= res_d;
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;
  assign result_o    = res_q;

endmodule

// ----- design/coreset0_occasion_locator.sv -----
// coreset0_occasion_locator: top level, type0 pdcch monitoring occasion locator
// depends on col_pkg, col_query_if, col_result_if, col_lookup, col_pipe
//
//   channel   direction  word                               handshake
//   query_i   in         frame_number, slot_number          valid/ready
//   result_o  out        status, is_occasion, coreset0 info  valid/ready
//   cfg       in         cfg_idx_i, cfg_data_i              cfg_we_i, no wait
//
// one query word is taken every cycle unless a result stall has filled the pipeline;
// each result passes through the four register stages of col_pipe
// the config lookup is registered, behind the config registers that a write updates
// reset clears the config registers (mib not valid) and all stage valid bits
// a stalled result holds in the last stage; earlier stages fill behind it,
// and query ready drops only when all four stages hold words
module coreset0_occasion_locator import col_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  col_query_if.sink            query_i,
  col_result_if.source         result_o
);

  logic    scs;
  info_t   info;
  result_t res;

  // configuration and table lookup
  col_lookup u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .scs_o      (scs),
    .info_o     (info)
  );

  // per-query pipeline
  col_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scs_i       (scs),
    .info_i      (info),
    .in_valid_i  (query_i.valid),
    .in_ready_o  (query_i.ready),
    .frame_lsb_i (query_i.frame_number[0]),
    .slot_i      (query_i.slot_number),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (res)
  );

  // result word onto the channel
  assign result_o.status            = res.status;
  assign result_o.is_occasion       = res.is_occasion;
  assign result_o.coreset_rbs       = res.rbs;
  assign result_o.coreset_symbols   = res.sym;
  assign result_o.coreset_rb_offset = res.rb_off;
  assign result_o.start_slot        = res.start_slot;
  assign result_o.odd_frame         = res.odd;
  assign result_o.first_symbol      = res.fsym;

endmodule

// ----- design/col_checker.sv -----
// col_checker: port-level assertions for coreset0_occasion_locator, with its bind
// depends on col_pkg for status codes and widths
module col_checker import col_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               q_valid_i,
  input logic               q_ready_i,
  input logic               r_valid_i,
  input logic               r_ready_i,
  input logic [STAT_W-1:0]  r_status_i,
  input logic               r_occ_i,
  input logic [RBS_W-1:0]   r_rbs_i,
  input logic [SYM_W-1:0]   r_sym_i,
  input logic [SLOT_W-1:0]  r_start_i
);

  // a stalled result stays valid; its status, occasion, rbs and start slot hold
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && !r_ready_i |=> r_valid_i && $stable(r_status_i) && $stable(r_occ_i)
      && $stable(r_rbs_i) && $stable(r_start_i))
    else $error("result word changed while stalled");

  // an empty output stage means the pipeline can take a word
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !r_valid_i |-> q_ready_i)
    else $error("query not ready with output stage empty");

  // errors never report an occasion or a coreset
  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && (r_status_i != STAT_OK) |-> !r_occ_i && (r_rbs_i == '0) && (r_sym_i == '0))
    else $error("error result carries occasion or coreset data");

  // good results carry a real coreset and a start slot below 20
  a_ok_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && (r_status_i == STAT_OK) |->
      (r_rbs_i != '0) && (r_sym_i != '0) && (r_start_i < 5'd20))
    else $error("ok result with empty coreset or bad start slot");

endmodule

bind coreset0_occasion_locator col_checker u_col_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .q_valid_i  (query_i.valid),
  .q_ready_i  (query_i.ready),
  .r_valid_i  (result_o.valid),
  .r_ready_i  (result_o.ready),
  .r_status_i (result_o.status),
  .r_occ_i    (result_o.is_occasion),
  .r_rbs_i    (result_o.coreset_rbs),
  .r_sym_i    (result_o.coreset_symbols),
  .r_start_i  (result_o.start_slot)
);

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for the coreset0 occasion locator
// depends on col_pkg, col_query_if, col_result_if and coreset0_occasion_locator
// directed rows then random config phases, checked by typed words or a predictor
`timescale 1ns / 100ps

module testbench;
  import col_pkg::*;

  localparam int DIR_ROWS     = 32;
  localparam int PHASES       = 36;
  localparam int PHASE_ITEMS  = 25;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  // typed-in words for rows that read straight off the tables
  localparam result_t NO_MIB_WORD =
    result_t'{STAT_NO_MIB, 1'b0, 7'd0, 2'd0, 6'd0, 5'd0, 1'b0, 2'd0};
  localparam result_t RESERVED_WORD =
    result_t'{STAT_RESERVED, 1'b0, 7'd0, 2'd0, 6'd0, 5'd0, 1'b0, 2'd0};
  localparam result_t ROW0_HIT_WORD =
    result_t'{STAT_OK, 1'b1, 7'd24, 2'd2, 6'd0, 5'd0, 1'b0, 2'd0};
  localparam result_t ROW0_MISS_WORD =
    result_t'{STAT_OK, 1'b0, 7'd24, 2'd2, 6'd0, 5'd0, 1'b0, 2'd0};

  // coreset0 rows, 15 kHz and 30 kHz
  localparam logic [6:0] CS15_RBS [16] = '{24, 24, 24, 24, 24, 24, 48, 48,
                                           48, 48, 48, 48, 96, 96, 96, 0};
  localparam logic [1:0] CS15_SYM [16] = '{2, 2, 2, 3, 3, 3, 1, 1,
                                           2, 2, 3, 3, 1, 2, 3, 0};
  localparam logic [5:0] CS15_OFF [16] = '{0, 2, 4, 0, 2, 4, 12, 16,
                                           12, 16, 12, 16, 38, 38, 38, 0};
  localparam logic [6:0] CS30_RBS [16] = '{24, 24, 24, 24, 24, 24, 24, 24,
                                           24, 24, 48, 48, 48, 48, 48, 48};
  localparam logic [1:0] CS30_SYM [16] = '{2, 2, 2, 2, 2, 3, 3, 3,
                                           3, 3, 1, 1, 1, 2, 2, 2};
  localparam logic [5:0] CS30_OFF [16] = '{0, 1, 2, 3, 4, 0, 1, 2,
                                           3, 4, 12, 14, 16, 12, 14, 16};

  // search space zero rows: slot offset, M in half units, first symbol
  localparam int SSZ_O     [16] = '{0, 0, 2, 2, 5, 5, 7, 7, 0, 5, 0, 0, 2, 2, 5, 5};
  localparam int SSZ_MHALF [16] = '{2, 1, 2, 1, 2, 1, 2, 1, 4, 4, 2, 2, 2, 2, 2, 2};
  localparam int SSZ_FSYM  [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 1, 2, 1, 2};

  typedef struct packed {
    logic        is_cfg;
    logic        scs;
    logic [3:0]  cset;
    logic [3:0]  ss;
    logic [2:0]  beam;
    logic        mib_ok;
    logic [9:0]  frame;
    logic [4:0]  slot;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  col_query_if  query_bus ();
  col_result_if result_bus ();

  coreset0_occasion_locator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .query_i    (query_bus),
    .result_o   (result_bus)
  );

  // shadow of the configuration registers
  logic       cfg_scs;
  logic [3:0] cfg_cset;
  logic [3:0] cfg_ss;
  logic [2:0] cfg_beam;
  logic       cfg_mib_ok;

  result_t   expected_words [$];
  stim_row_t dir_rows [DIR_ROWS];
  int        mismatch_count;
  int        quiet_cycles;
  bit        calm;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // expected word for one frame and slot under the shadow config
  function automatic result_t predict_occasion(input logic [9:0] frame, input logic [4:0] slot);
    result_t w;
    int nslot, total, n0, parity, period, abs_slot, offset;
    w = '0;
    if (!cfg_mib_ok) begin
      w.status = STAT_NO_MIB;
      return w;
    end
    if (cfg_scs) begin
      nslot = 20;
      w.rbs = CS30_RBS[cfg_cset];
      w.sym = CS30_SYM[cfg_cset];
      w.rb_off = CS30_OFF[cfg_cset];
    end else begin
      if (cfg_cset == CSET_RESERVED) begin
        w.status = STAT_RESERVED;
        return w;
      end
      nslot = 10;
      w.rbs = CS15_RBS[cfg_cset];
      w.sym = CS15_SYM[cfg_cset];
      w.rb_off = CS15_OFF[cfg_cset];
    end
    total = (SSZ_O[cfg_ss] << cfg_scs) + ((int'(cfg_beam) * SSZ_MHALF[cfg_ss]) >> 1);
    n0 = total % nslot;
    parity = (total / nslot) % 2;
    // odd beams in the alternating rows start right after coreset0
    if (cfg_ss < 4'd8 && cfg_ss[0] && cfg_beam[0])
      w.fsym = w.sym;
    else
      w.fsym = 2'(SSZ_FSYM[cfg_ss]);
    period = 2 * nslot;
    abs_slot = (int'(frame) * nslot + int'(slot)) % period;
    offset = n0 + nslot * parity;
    w.status = STAT_OK;
    w.is_occasion = ((abs_slot + period - offset) % period) < 2;
    w.start_slot = n0[4:0];
    w.odd = parity[0];
    return w;
  endfunction

  function automatic stim_row_t cfg_row(input logic scs, input logic [3:0] cset,
                                        input logic [3:0] ss, input logic [2:0] beam,
                                        input logic mib_ok);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.scs = scs;
    r.cset = cset;
    r.ss = ss;
    r.beam = beam;
    r.mib_ok = mib_ok;
    return r;
  endfunction

  function automatic stim_row_t query_row(input logic [9:0] frame, input logic [4:0] slot);
    stim_row_t r;
    r = '0;
    r.frame = frame;
    r.slot = slot;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [9:0] frame, input logic [4:0] slot,
                                          input result_t want);
    stim_row_t r;
    r = query_row(frame, slot);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic logic [3:0] pick_row();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 4'd0;
    if (roll < 40) return 4'd15;
    return 4'($urandom_range(15));
  endfunction

  // all five registers, one per edge, then let the lookup settle
  task automatic write_config(input logic scs, input logic [3:0] cset, input logic [3:0] ss,
                              input logic [2:0] beam, input logic mib_ok);
    cfg_reg_e   order [5];
    logic [3:0] vals [5];
    int         k;
    order = '{REG_SCS, REG_CORESET, REG_SEARCH, REG_BEAM, REG_VALID};
    vals = '{{3'd0, scs}, cset, ss, {1'b0, beam}, {3'd0, mib_ok}};
    for (k = 0; k < 5; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= order[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_scs = scs;
    cfg_cset = cset;
    cfg_ss = ss;
    cfg_beam = beam;
    cfg_mib_ok = mib_ok;
    repeat (2) @(posedge clk_i);
  endtask

  // one query word; valid stays high on return, caller sends again or stops
  task automatic send_query(input logic [9:0] frame, input logic [4:0] slot,
                            input logic typed, input result_t want);
    while (!calm && $urandom_range(99) < 22) begin
      query_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    query_bus.valid <= 1'b1;
    query_bus.frame_number <= frame;
    query_bus.slot_number <= slot;
    @(posedge clk_i);
    while (!query_bus.ready) @(posedge clk_i);
    expected_words.push_back(typed ? want : predict_occasion(frame, slot));
  endtask

  task automatic stop_queries();
    query_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls and the compare against the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = result_t'{status_e'(result_bus.status), result_bus.is_occasion,
                        result_bus.coreset_rbs, result_bus.coreset_symbols,
                        result_bus.coreset_rb_offset, result_bus.start_slot,
                        result_bus.odd_frame, result_bus.first_symbol};
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: st %0d occ %0d", got.status, got.is_occasion);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: want st %0d occ %0d rbs %0d sym %0d off %0d n0 %0d ",
                        "odd %0d fs %0d, got st %0d occ %0d rbs %0d sym %0d off %0d ",
                        "n0 %0d odd %0d fs %0d"},
                       want.status, want.is_occasion, want.rbs, want.sym, want.rb_off,
                       want.start_slot, want.odd, want.fsym,
                       got.status, got.is_occasion, got.rbs, got.sym, got.rb_off,
                       got.start_slot, got.odd, got.fsym);
          end
        end
      end
      result_bus.ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((query_bus.valid && query_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int i, ph, n, roll, nslot, walk_frame, walk_slot;
    logic [9:0] frame;
    logic [4:0] slot;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    query_bus.valid = 1'b0;
    query_bus.frame_number = '0;
    query_bus.slot_number = '0;
    cfg_scs = 1'b0;
    cfg_cset = '0;
    cfg_ss = '0;
    cfg_beam = '0;
    cfg_mib_ok = 1'b0;
    calm = 1'b0;

    dir_rows = '{
      // after reset the mib is not valid
      typed_row(10'd0, 5'd0, NO_MIB_WORD),
      typed_row(10'd1023, 5'd31, NO_MIB_WORD),
      // reserved 15 kHz row
      cfg_row(1'b0, 4'd15, 4'd0, 3'd0, 1'b1),
      typed_row(10'd0, 5'd0, RESERVED_WORD),
      typed_row(10'd1023, 5'd19, RESERVED_WORD),
      // invalid mib wins over the reserved row
      cfg_row(1'b0, 4'd15, 4'd0, 3'd0, 1'b0),
      typed_row(10'd5, 5'd3, NO_MIB_WORD),
      // first rows: slots 0 and 1 of frame 0 hit, slot 2 and frame 1 miss
      cfg_row(1'b0, 4'd0, 4'd0, 3'd0, 1'b1),
      typed_row(10'd0, 5'd0, ROW0_HIT_WORD),
      typed_row(10'd0, 5'd1, ROW0_HIT_WORD),
      typed_row(10'd0, 5'd2, ROW0_MISS_WORD),
      query_row(10'd1, 5'd0),
      // all registers at their top values
      cfg_row(1'b1, 4'd15, 4'd15, 3'd7, 1'b1),
      query_row(10'd1023, 5'd19),
      query_row(10'd1022, 5'd31),
      // alternating first symbol, odd then even beam
      cfg_row(1'b0, 4'd4, 4'd1, 3'd1, 1'b1),
      query_row(10'd0, 5'd0),
      cfg_row(1'b0, 4'd3, 4'd7, 3'd6, 1'b1),
      query_row(10'd1, 5'd0),
      // second slot wraps into the next frame, 15 kHz
      cfg_row(1'b0, 4'd0, 4'd4, 3'd4, 1'b1),
      query_row(10'd0, 5'd9),
      query_row(10'd1, 5'd0),
      query_row(10'd1, 5'd1),
      // same wrap at 30 kHz
      cfg_row(1'b1, 4'd10, 4'd6, 3'd5, 1'b1),
      query_row(10'd2, 5'd19),
      query_row(10'd3, 5'd0),
      // M of two, slot numbers past the frame
      cfg_row(1'b0, 4'd12, 4'd8, 3'd7, 1'b1),
      query_row(10'd1, 5'd4),
      query_row(10'd0, 5'd31),
      query_row(10'd1023, 5'd25),
      cfg_row(1'b1, 4'd0, 4'd9, 3'd7, 1'b1),
      query_row(10'd0, 5'd0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].is_cfg) begin
        stop_queries();
        drain();
        write_config(dir_rows[i].scs, dir_rows[i].cset, dir_rows[i].ss,
                     dir_rows[i].beam, dir_rows[i].mib_ok);
      end else begin
        send_query(dir_rows[i].frame, dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    stop_queries();

    // random config phases, mostly slot walks through the two-frame period
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph >= 14 && ph < 20);
      if (ph == 0)
        write_config(1'b1, 4'd15, 4'd15, 3'd7, 1'b1);
      else if (ph == 1)
        write_config(1'b0, 4'd0, 4'd0, 3'd0, 1'b1);
      else
        write_config(1'($urandom_range(1)), pick_row(), pick_row(),
                     ($urandom_range(2) == 0) ? 3'($urandom_range(1) * 7)
                                              : 3'($urandom_range(7)),
                     $urandom_range(9) != 0);
      nslot = cfg_scs ? 20 : 10;
      walk_frame = $urandom_range(1023);
      walk_slot = $urandom_range(nslot - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          frame = 10'(walk_frame);
          slot = 5'(walk_slot);
          walk_slot++;
          if (walk_slot == nslot) begin
            walk_slot = 0;
            walk_frame = (walk_frame + 1) % 1024;
          end
        end else if (roll < 85) begin
          frame = 10'($urandom_range(1023));
          slot = 5'($urandom_range(nslot - 1));
        end else begin
          frame = 10'($urandom_range(1023));
          slot = 5'($urandom_range(31));
        end
        send_query(frame, slot, 1'b0, NO_MIB_WORD);
      end
      stop_queries();
    end

    // wait out the pipeline, then report
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
